[sv/dmx_pkg.sv]
// Shared constants, request codes and types for the DMX512 frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package dmx_pkg;

    localparam int SLOTS  = 512;
    localparam int DEPTH  = SLOTS + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 10;
    localparam int AGE_W  = 16;
    localparam int REQ_W  = 3;
    localparam int ST_W   = 2;

    localparam logic [CNT_W-1:0] SLOT_MAX  = CNT_W'(SLOTS);
    localparam logic [CNT_W-1:0] SLOT_LIM  = CNT_W'(DEPTH);
    localparam logic [AGE_W-1:0] AGE_MAX   = {AGE_W{1'b1}};
    localparam logic [AGE_W-1:0] TIMEOUT_RST = AGE_W'(1000);

    localparam logic [REQ_W-1:0] REQ_BYTE  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_BREAK = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ERROR = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_WRITE = 3'd4;
    localparam logic [REQ_W-1:0] REQ_TICK  = 3'd5;

    localparam logic [ST_W-1:0] ST_IDLE  = 2'd0;
    localparam logic [ST_W-1:0] ST_BREAK = 2'd1;
    localparam logic [ST_W-1:0] ST_DATA  = 2'd2;

    // one slot store access
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    // result fields known at request time
    typedef struct packed {
        logic             is_read;
        logic             healthy;
        logic [ST_W-1:0]  frame_state;
        logic [CNT_W-1:0] slot_count;
    } status_t;

endpackage

`default_nettype wire

[sv/dmx_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module dmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 513,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic             re,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/dmx_rx_fsm.sv]
// Receiver state, write pointer, packet age and slot store request generation.
`timescale 1ns / 1ps
`default_nettype none

module dmx_rx_fsm
    import dmx_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [REQ_W-1:0] req_type,
    input  wire logic [7:0]       data_byte,
    input  wire logic [9:0]       channel,
    input  wire logic [AGE_W-1:0] timeout,
    output mem_req_t              mem_req,
    output status_t               status
);

    logic [ST_W-1:0]  state_reg, state_next;
    logic [CNT_W-1:0] wp_reg, wp_next;
    logic [AGE_W-1:0] age_reg, age_next;
    logic             ch_ok;
    logic [ST_W-1:0]  st_eff;
    logic [CNT_W-1:0] wp_eff;

    assign ch_ok = (channel != 10'd0) && (channel <= SLOT_MAX);

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        age_next   = age_reg;
        st_eff     = state_reg;
        wp_eff     = wp_reg;
        mem_req    = '0;
        mem_req.wdata = data_byte;
        status     = '0;
        if (accept)
        begin
            unique case (req_type)
                REQ_BYTE:
                begin
                    // start code check right after a break
                    if (state_reg == ST_BREAK)
                    begin
                        if (data_byte == 8'd0)
                        begin
                            st_eff   = ST_DATA;
                            wp_eff   = '0;
                            age_next = '0;
                        end
                        else
                        begin
                            st_eff = ST_IDLE;
                        end
                    end
                    state_next = st_eff;
                    if (st_eff == ST_DATA && wp_eff < SLOT_LIM)
                    begin
                        mem_req.we   = 1'b1;
                        mem_req.addr = wp_eff[ADDR_W-1:0];
                        wp_next      = wp_eff + CNT_W'(1);
                    end
                    else
                    begin
                        wp_next = wp_eff;
                    end
                end
                REQ_BREAK: state_next = ST_BREAK;
                REQ_ERROR: state_next = ST_IDLE;
                REQ_READ:
                begin
                    mem_req.re     = ch_ok;
                    mem_req.addr   = channel[ADDR_W-1:0];
                    status.is_read = ch_ok;
                end
                REQ_WRITE:
                begin
                    mem_req.we   = ch_ok;
                    mem_req.addr = channel[ADDR_W-1:0];
                end
                REQ_TICK:
                begin
                    if (age_reg != AGE_MAX)
                    begin
                        age_next = age_reg + AGE_W'(1);
                    end
                end
                default: ;
            endcase
        end
        status.healthy     = (age_next < timeout);
        status.frame_state = state_next;
        status.slot_count  = wp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            age_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            age_reg   <= age_next;
        end
    end

endmodule

`default_nettype wire

[sv/dmx512_frame_receiver.sv]
// Top level of the DMX512 frame receiver: slot store, clear pass and result pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// in        in_valid/in_stall    req_type, data_byte, channel
// out       out_valid/out_stall  read_data, healthy, frame_state, slot_count
// cfg       cfg_valid/cfg_ready  cfg_data (health_timeout)
//
// One request per cycle sustained while in_stall is low; each result passes
// through stage 1 (slot store read), then the output register.
// The single-port slot store takes one access per request, which sets the rate.
// After reset a clear pass zeroes all DEPTH (513) store entries, with in_stall high.
// A stalled output holds one result; a second finished request waits in stage 1,
// and outside the clear pass in_stall rises only when both are full.
module dmx512_frame_receiver
    import dmx_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [REQ_W-1:0] req_type,
    input  wire logic [7:0]       data_byte,
    input  wire logic [9:0]       channel,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [7:0]            read_data,
    output logic                  healthy,
    output logic [ST_W-1:0]       frame_state,
    output logic [CNT_W-1:0]      slot_count,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [AGE_W-1:0] cfg_data
);

    logic [AGE_W-1:0]  timeout_reg;
    logic              clear_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              accept;
    mem_req_t          fsm_req;
    mem_req_t          ram_req;
    status_t           fsm_status;
    logic [7:0]        ram_rdata;

    // stage 1: request issued to the store, read data arrives here
    logic              s1_valid_reg, s1_valid_next;
    status_t           s1_status_reg;
    logic              s1_adv;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_rd_reg;
    status_t           out_status_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
        end
        else if (cfg_valid)
        begin
            timeout_reg <= cfg_data;
        end
    end

    // clear pass over the store after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = clear_reg || (s1_valid_reg && !s1_adv);
    assign accept   = in_valid && !in_stall;

    dmx_rx_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (req_type),
        .data_byte (data_byte),
        .channel   (channel),
        .timeout   (timeout_reg),
        .mem_req   (fsm_req),
        .status    (fsm_status)
    );

    always_comb
    begin
        if (clear_reg)
        begin
            ram_req.we    = 1'b1;
            ram_req.re    = 1'b0;
            ram_req.addr  = clr_addr_reg;
            ram_req.wdata = 8'd0;
        end
        else
        begin
            ram_req = fsm_req;
        end
    end

    dmx_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .re    (ram_req.re),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    // read data stays put while stage 1 waits: no new access is issued then
    assign s1_valid_next  = accept || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= fsm_status;
        end
        if (s1_adv)
        begin
            out_status_reg <= s1_status_reg;
            out_rd_reg     <= s1_status_reg.is_read ? ram_rdata : 8'd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = out_rd_reg;
    assign healthy     = out_status_reg.healthy;
    assign frame_state = out_status_reg.frame_state;
    assign slot_count  = out_status_reg.slot_count;

    a_slot_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> slot_count <= SLOT_LIM)
        else $error("slot count beyond store depth");

    a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.we && ram_req.re))
        else $error("store read and write in one cycle");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_status_reg))
        else $error("stage 1 lost a waiting request");

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clear_reg) |-> $past(clr_addr_reg) == ADDR_W'(DEPTH - 1))
        else $error("clear pass ended early");

    a_no_read_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> !accept && !s1_valid_reg)
        else $error("request taken during clear pass");

endmodule

`default_nettype wire
